// ----- design/led_bar_frame_serializer_core_assert.svh -----
// Assertion macros shared by the serializer modules.
`ifndef LED_BAR_FRAME_SERIALIZER_CORE_ASSERT_SVH
`define LED_BAR_FRAME_SERIALIZER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LBFS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lbfs assertion failed");

`define LBFS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lbfs assertion failed");

`else

`define LBFS_ASSERT(lbl, expr)

`define LBFS_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ----- design/lbfs_pkg.sv -----
package lbfs_pkg;

  localparam int LBFS_LED_COUNT = 10;
  localparam int LBFS_PAD_WORDS = 4;

  localparam int WAIT_W = 17;

  localparam logic [2:0] CFG_COMMAND_WORD = 3'd0;
  localparam logic [2:0] CFG_START_DELAY  = 3'd1;
  localparam logic [2:0] CFG_LATCH_WAIT   = 3'd2;
  localparam logic [2:0] CFG_PULSE_TICKS  = 3'd3;
  localparam logic [2:0] CFG_PULSE_COUNT  = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_LATCH_LOW,
    PH_PULSE_HIGH,
    PH_PULSE_LOW,
    PH_LATCH_END
  } ph_t;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SET_ONE  = 3'd1,
    OP_SET_ALL  = 3'd2,
    OP_READ_ONE = 3'd3,
    OP_START    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BUSY      = 2'd2
  } st_t;

  typedef struct packed {
    logic out_load;
    logic set_one;
    logic set_all;
    logic rd_cmd;
    logic frame_start;
    logic wait_dec;
    logic shift_evt;
    logic latch_low;
    logic pulse_high;
    logic pulse_low;
    logic latch_end;
  } lbfs_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic wait_zero;
    logic frame_last;
    logic pulse_last;
  } lbfs_stat_t;

endpackage

// ----- design/lbfs_dp.sv -----
`include "led_bar_frame_serializer_core_assert.svh"

module lbfs_dp #(
  parameter int LED_COUNT = lbfs_pkg::LBFS_LED_COUNT,
  parameter int PAD_WORDS = lbfs_pkg::LBFS_PAD_WORDS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [3:0]          led_index,
  input  logic [7:0]          level,
  input  lbfs_pkg::lbfs_cmd_t cmd,
  output lbfs_pkg::lbfs_stat_t stat,
  output logic                ser_data,
  output logic                ser_clock,
  output logic [7:0]          read_level
);
  import lbfs_pkg::*;

  localparam int HDR_UNITS = 1 + LED_COUNT;
  localparam int TOTAL     = HDR_UNITS + PAD_WORDS;
  localparam int WC_W      = $clog2(TOTAL + 1);
  localparam int LIDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic [WC_W-1:0] HDR_WC  = WC_W'(HDR_UNITS);
  localparam logic [WC_W-1:0] LAST_WC = WC_W'(TOTAL - 1);
  localparam logic [WC_W-1:0] LED_WC  = WC_W'(LED_COUNT);
  localparam logic [3:0]      LED_IDX = 4'(LED_COUNT);
  localparam logic [3:0]      BIT_LAST_WORD = 4'd15;
  localparam logic [3:0]      BIT_LAST_PAD  = 4'd7;

  // config registers
  logic [15:0] command_word;
  logic [15:0] start_delay;
  logic [15:0] latch_wait;
  logic [7:0]  pulse_ticks;
  logic [3:0]  pulse_count;

  // brightness store: entries not written since the last set-all read as all_level
  logic [7:0]           mem [LED_COUNT];
  logic [LED_COUNT-1:0] written;
  logic [7:0]           all_level;

  logic [WC_W-1:0]   wc, wc_next;
  logic [3:0]        bc, bc_next;
  logic [WAIT_W-1:0] wait_cnt, wait_next;
  logic [3:0]        pc, pc_next;
  logic              data_level, data_next;
  logic              clock_level, clock_next;

  logic              idx_ok;
  logic [LIDX_W-1:0] idx;
  logic [LIDX_W-1:0] rd_addr;
  logic [WC_W-1:0]   wc_sub;
  logic              fb_ok;
  logic [LIDX_W-1:0] fb_addr;

  logic [7:0] fb_mem_q;
  logic       fb_wr_q;
  logic [7:0] frame_byte;
  logic [7:0] rd_mem_q;
  logic       rd_wr_q;
  logic [7:0] rd_all_q;
  logic       rd_ok_q;

  logic              hdr;
  logic              len_last;
  logic [15:0]       shift_word;
  logic              shift_bit;
  logic              pulse_last;
  logic [3:0]        pc_init;
  logic [7:0]        half_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_word <= 16'd0;
      start_delay  <= 16'd250;
      latch_wait   <= 16'd250;
      pulse_ticks  <= 8'd1;
      pulse_count  <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMMAND_WORD: command_word <= cfg_data;
        CFG_START_DELAY:  start_delay  <= cfg_data;
        CFG_LATCH_WAIT:   latch_wait   <= cfg_data;
        CFG_PULSE_TICKS:  pulse_ticks  <= cfg_data[7:0];
        CFG_PULSE_COUNT:  pulse_count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign idx_ok  = led_index < LED_IDX;
  assign idx     = led_index[LIDX_W-1:0];
  assign rd_addr = idx_ok ? idx : '0;

  assign wc_sub  = wc_next - 1'b1;
  assign fb_ok   = (wc_next != '0) && (wc_next <= LED_WC);
  assign fb_addr = fb_ok ? wc_sub[LIDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      all_level <= 8'd0;
    end else if (cmd.set_all) begin
      written   <= '0;
      all_level <= level;
    end else if (cmd.set_one) begin
      written[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_one) begin
      mem[idx] <= level;
    end
    fb_mem_q <= mem[fb_addr];
    fb_wr_q  <= written[fb_addr];
    if (cmd.out_load) begin
      rd_mem_q <= mem[rd_addr];
      rd_wr_q  <= written[rd_addr];
      rd_all_q <= all_level;
      rd_ok_q  <= cmd.rd_cmd && idx_ok;
    end
  end

  assign frame_byte = fb_wr_q ? fb_mem_q : all_level;
  assign read_level = rd_ok_q ? (rd_wr_q ? rd_mem_q : rd_all_q) : 8'd0;

  assign hdr        = wc < HDR_WC;
  assign len_last   = hdr ? (bc == BIT_LAST_WORD) : (bc == BIT_LAST_PAD);
  assign shift_word = (wc == '0) ? command_word : {8'h00, frame_byte};
  assign shift_bit  = hdr & shift_word[~bc];
  assign pulse_last = pc <= 4'd1;
  assign pc_init    = (pulse_count == 4'd0) ? 4'd1 : pulse_count;
  assign half_m1    = (pulse_ticks == 8'd0) ? 8'd0 : pulse_ticks - 8'd1;

  always_comb begin
    wc_next    = wc;
    bc_next    = bc;
    wait_next  = wait_cnt;
    pc_next    = pc;
    data_next  = data_level;
    clock_next = clock_level;
    if (cmd.frame_start) begin
      wc_next   = '0;
      bc_next   = 4'd0;
      wait_next = WAIT_W'(start_delay);
    end
    if (cmd.wait_dec) begin
      wait_next = wait_cnt - 1'b1;
    end
    if (cmd.shift_evt) begin
      data_next  = shift_bit;
      clock_next = ~clock_level;
      if (len_last) begin
        bc_next = 4'd0;
        wc_next = wc + 1'b1;
      end else begin
        bc_next = bc + 4'd1;
      end
    end
    if (cmd.latch_low) begin
      data_next = 1'b0;
      wait_next = WAIT_W'(latch_wait);
      pc_next   = pc_init;
    end
    if (cmd.pulse_high) begin
      data_next = 1'b1;
      wait_next = WAIT_W'(half_m1);
    end
    if (cmd.pulse_low) begin
      data_next = 1'b0;
      pc_next   = (pc != 4'd0) ? pc - 4'd1 : pc;
      wait_next = pulse_last ? WAIT_W'(half_m1) + WAIT_W'(latch_wait) : WAIT_W'(half_m1);
    end
    if (cmd.latch_end) begin
      clock_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc          <= '0;
      bc          <= 4'd0;
      wait_cnt    <= '0;
      pc          <= 4'd0;
      data_level  <= 1'b0;
      clock_level <= 1'b0;
    end else begin
      wc          <= wc_next;
      bc          <= bc_next;
      wait_cnt    <= wait_next;
      pc          <= pc_next;
      data_level  <= data_next;
      clock_level <= clock_next;
    end
  end

  assign stat.idx_ok     = idx_ok;
  assign stat.wait_zero  = wait_cnt == '0;
  assign stat.frame_last = (wc == LAST_WC) && len_last;
  assign stat.pulse_last = pulse_last;

  assign ser_data  = data_level;
  assign ser_clock = clock_level;

  `LBFS_ASSERT_NEXT(a_pins_hold, !cmd.out_load, $stable(data_level) && $stable(clock_level))
  `LBFS_ASSERT_NEXT(a_latch_end_clk, cmd.latch_end, !clock_level)
  `LBFS_ASSERT(a_pad_bits, hdr || (bc <= BIT_LAST_PAD))

endmodule

// ----- design/lbfs_ctrl.sv -----
`include "led_bar_frame_serializer_core_assert.svh"

module lbfs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           opcode,
  input  lbfs_pkg::lbfs_stat_t stat,
  output lbfs_pkg::lbfs_cmd_t  cmd,
  output logic                 busy_res,
  output logic [1:0]           status
);
  import lbfs_pkg::*;

  ph_t  phase, phase_next;
  st_t  status_q, status_next;
  logic accept;
  logic busy;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign busy     = phase != PH_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      status_q  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        status_q  <= status_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd         = '0;
    phase_next  = phase;
    status_next = ST_OK;
    if (accept) begin
      cmd.out_load = 1'b1;
      unique case (op_t'(opcode))
        OP_TICK: begin
          if (busy && !stat.wait_zero) begin
            cmd.wait_dec = 1'b1;
          end else begin
            unique case (phase)
              PH_SHIFT: begin
                cmd.shift_evt = 1'b1;
                if (stat.frame_last) phase_next = PH_LATCH_LOW;
              end
              PH_LATCH_LOW: begin
                cmd.latch_low = 1'b1;
                phase_next    = PH_PULSE_HIGH;
              end
              PH_PULSE_HIGH: begin
                cmd.pulse_high = 1'b1;
                phase_next     = PH_PULSE_LOW;
              end
              PH_PULSE_LOW: begin
                cmd.pulse_low = 1'b1;
                phase_next    = stat.pulse_last ? PH_LATCH_END : PH_PULSE_HIGH;
              end
              PH_LATCH_END: begin
                cmd.latch_end = 1'b1;
                phase_next    = PH_IDLE;
              end
              default: ;
            endcase
          end
        end
        OP_SET_ONE: begin
          if (busy) status_next = ST_BUSY;
          else if (!stat.idx_ok) status_next = ST_BAD_INDEX;
          else cmd.set_one = 1'b1;
        end
        OP_SET_ALL: begin
          if (busy) status_next = ST_BUSY;
          else cmd.set_all = 1'b1;
        end
        OP_READ_ONE: begin
          cmd.rd_cmd = 1'b1;
          if (!stat.idx_ok) status_next = ST_BAD_INDEX;
        end
        OP_START: begin
          if (busy) begin
            status_next = ST_BUSY;
          end else begin
            cmd.frame_start = 1'b1;
            phase_next      = PH_SHIFT;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_res = busy;
  assign status   = status_q;

  `LBFS_ASSERT_NEXT(a_phase_on_accept, !accept, $stable(phase))
  `LBFS_ASSERT_NEXT(a_idle_start, accept && phase == PH_IDLE && opcode != OP_START, phase == PH_IDLE)
  `LBFS_ASSERT_NEXT(a_result_after_accept, accept, out_valid)

endmodule

// ----- design/led_bar_frame_serializer_core.sv -----
// LED bar frame serializer.
// Input channel (in_valid/in_ready) carries one command word: opcode, led_index,
// level. Each accepted word yields exactly one result word on the output channel
// (out_valid/out_ready): ser_data, ser_clock, busy_res, read_level, status.
// A word is processed in the cycle it is accepted; its result is registered and
// shows up in the next cycle. New words are taken every cycle while the output
// register is empty or being drained, so throughput is one word per cycle.
// A stalled receiver holds the result and blocks the input until it is taken.
// Tick commands advance the serial frame by one pin event or one wait count.
// The brightness store is a small register file with a registered read port for
// read commands and one for the frame shifter.
// Config registers are written through cfg_we/cfg_index/cfg_data, no wait.
// Reset (rst, synchronous) brings the sequencer to idle, pins low, all levels
// zero and config registers to defaults; no clearing pass is needed.
module led_bar_frame_serializer_core #(
  parameter int LED_COUNT = lbfs_pkg::LBFS_LED_COUNT,
  parameter int PAD_WORDS = lbfs_pkg::LBFS_PAD_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [3:0]  led_index,
  input  logic [7:0]  level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ser_data,
  output logic        ser_clock,
  output logic        busy_res,
  output logic [7:0]  read_level,
  output logic [1:0]  status
);
  import lbfs_pkg::*;

  lbfs_cmd_t  cmd;
  lbfs_stat_t stat;

  lbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .opcode    (opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy_res  (busy_res),
    .status    (status)
  );

  lbfs_dp #(
    .LED_COUNT (LED_COUNT),
    .PAD_WORDS (PAD_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .led_index  (led_index),
    .level      (level),
    .cmd        (cmd),
    .stat       (stat),
    .ser_data   (ser_data),
    .ser_clock  (ser_clock),
    .read_level (read_level)
  );

endmodule
